/* design/spq_pkg.sv */
package spq_pkg;

  localparam int OP_W     = 2;
  localparam int DATA_W   = 32;
  localparam int PRIO_W   = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic                insert;    // place the request item in order
    logic                remove;    // drop the head entry
    logic                read_head; // return the head payload
    logic                load_rsp;  // capture the response registers
    logic [STATUS_W-1:0] status;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
  } dp_stat_t;

endpackage

/* design/spq_req_if.sv */
interface spq_req_if;
  import spq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [DATA_W-1:0] data_in;
  logic signed [PRIO_W-1:0] priority_req;

  modport source (output valid, output operation, output data_in, output priority_req,
                  input ready);
  modport sink   (input valid, input operation, input data_in, input priority_req,
                  output ready);
endinterface

/* design/spq_rsp_if.sv */
interface spq_rsp_if;
  import spq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] data_out;
  logic [COUNT_W-1:0]       count;
  logic                     not_empty;

  modport source (output valid, output status, output data_out, output count,
                  output not_empty, input ready);
  modport sink   (input valid, input status, input data_out, input count,
                  input not_empty, output ready);
endinterface

/* design/sorted_priority_queue.sv */
// Channel | Dir | Handshake         | Payload
// req_i   | in  | valid/ready       | operation, data_in, priority_req
// rsp_o   | out | valid/ready       | status, data_out, count, not_empty
//
// Each request is executed in the cycle it is accepted; its response is
// registered and shows in the next cycle. One request per cycle is sustained
// while no response stalls: the cell array shifts an insert or remove into place.
// Reset clears the entry count and the response register's valid flag.
// A stalled response holds, and a new request is taken only in the cycle
// the waiting response leaves.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int CAPACITY      = 16,
  parameter int PRIORITY_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_req_if.sink   req_i,
  spq_rsp_if.source rsp_o
);

  cmd_t     cmd;
  dp_stat_t stat;

  // Controller: accept requests, decode the operation into datapath commands,
  // and track whether a response waits.
  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_op_i    (req_i.operation),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath: sorted cell array (head at cell zero), entry count and
  // response registers.
  spq_dpath #(
    .CAPACITY      (CAPACITY),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .data_in_i      (req_i.data_in),
    .priority_req_i (req_i.priority_req),
    .stat_o         (stat),
    .status_o       (rsp_o.status),
    .data_out_o     (rsp_o.data_out),
    .count_o        (rsp_o.count),
    .not_empty_o    (rsp_o.not_empty)
  );

endmodule

/* design/spq_ctrl.sv */
module spq_ctrl
  import spq_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  logic [OP_W-1:0] req_op_i,
  output logic            req_ready_o,
  output logic            rsp_valid_o,
  input  logic            rsp_ready_i,
  input  dp_stat_t        stat_i,
  output cmd_t            cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_HOLD = 1'b1;

  logic state_q, state_d;
  logic accept;
  logic is_read;

  // Free when no response waits, or the waiting one leaves this cycle.
  assign req_ready_o = (state_q == S_IDLE) || rsp_ready_i;
  assign rsp_valid_o = (state_q == S_HOLD);
  assign accept      = req_valid_i && req_ready_o;

  always_comb begin
    is_read = req_op_i inside {OP_REMOVE, OP_PEEK};
    cmd_o.insert    = accept && (req_op_i == OP_INSERT) && !stat_i.full;
    cmd_o.remove    = accept && (req_op_i == OP_REMOVE) && !stat_i.empty;
    cmd_o.read_head = accept && is_read && !stat_i.empty;
    cmd_o.load_rsp  = accept;
    if ((req_op_i == OP_INSERT) && stat_i.full) begin
      cmd_o.status = ST_FULL;
    end else if (is_read && stat_i.empty) begin
      cmd_o.status = ST_EMPTY;
    end else begin
      cmd_o.status = ST_DONE;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_HOLD;
      end
      S_HOLD: begin
        if (rsp_ready_i && !accept) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* design/spq_dpath.sv */
module spq_dpath
  import spq_pkg::*;
#(
  parameter int CAPACITY      = 16,
  parameter int PRIORITY_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  input  logic signed [DATA_W-1:0] data_in_i,
  input  logic signed [PRIO_W-1:0] priority_req_i,
  output dp_stat_t                 stat_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic signed [DATA_W-1:0] data_out_o,
  output logic [COUNT_W-1:0]       count_o,
  output logic                     not_empty_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [DATA_W-1:0]               payload_q [CAPACITY];
  logic [DATA_W-1:0]               payload_d [CAPACITY];
  logic signed [PRIORITY_BITS-1:0] prio_q    [CAPACITY];
  logic signed [PRIORITY_BITS-1:0] prio_d    [CAPACITY];
  logic [CAPACITY-1:0]             stay;
  logic [CNT_W-1:0]                count_q, count_d;
  logic signed [PRIORITY_BITS+PRIO_W-1:0] prio_ext;
  logic signed [PRIORITY_BITS-1:0] prio_new;

  logic [STATUS_W-1:0]      status_q;
  logic signed [DATA_W-1:0] data_q;
  logic [COUNT_W-1:0]       rsp_count_q;
  logic                     not_empty_q;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CNT_W'(CAPACITY));

  // Sign-extend the field, then keep the low PRIORITY_BITS bits.
  assign prio_ext = {{PRIORITY_BITS{priority_req_i[PRIO_W-1]}}, priority_req_i};
  assign prio_new = prio_ext[PRIORITY_BITS-1:0];

  // A cell keeps its entry when it is live and ranks equal or above the new item.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      stay[i] = (CNT_W'(i) < count_q) && (prio_q[i] >= prio_new);
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      payload_d[i] = payload_q[i];
      prio_d[i]    = prio_q[i];
      if (cmd_i.insert && !stay[i]) begin
        if (i == 0 || stay[(i == 0) ? 0 : i-1]) begin
          payload_d[i] = data_in_i;
          prio_d[i]    = prio_new;
        end else begin
          payload_d[i] = payload_q[(i == 0) ? 0 : i-1];
          prio_d[i]    = prio_q[(i == 0) ? 0 : i-1];
        end
      end else if (cmd_i.remove && (i < CAPACITY - 1)) begin
        payload_d[i] = payload_q[(i < CAPACITY - 1) ? i+1 : i];
        prio_d[i]    = prio_q[(i < CAPACITY - 1) ? i+1 : i];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.insert) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.remove) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAPACITY; i++) begin
      payload_q[i] <= payload_d[i];
      prio_q[i]    <= prio_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_rsp) begin
      status_q    <= cmd_i.status;
      data_q      <= cmd_i.read_head ? payload_q[0] : '0;
      rsp_count_q <= COUNT_W'(count_d);
      not_empty_q <= (count_d != '0);
    end
  end

  assign status_o    = status_q;
  assign data_out_o  = data_q;
  assign count_o     = rsp_count_q;
  assign not_empty_o = not_empty_q;

endmodule
